@@ sv/css_tok_pkg.sv @@
`timescale 1ns / 1ps

package css_tok_pkg;

	typedef enum logic [3:0] {
		PH_INITIAL     = 4'd0,
		PH_BEFORE_SEL  = 4'd1,
		PH_SEL         = 4'd2,
		PH_AFTER_SEL   = 4'd3,
		PH_BEFORE_DECL = 4'd4,
		PH_DECL        = 4'd5,
		PH_CMT_OPEN    = 4'd6,
		PH_CMT_BODY    = 4'd7,
		PH_CMT_STAR    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,
		K_END  = 2'd1,
		K_EOF  = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_BAD_START   = 3'd0,
		E_DIGIT_START = 3'd1,
		E_UNDERSCORE  = 3'd2,
		E_BAD_SEL     = 3'd3,
		E_BAD_CMT     = 3'd4,
		E_OPEN_CMT    = 3'd5,
		E_BRACE_DECL  = 3'd6,
		E_MID_TOKEN   = 3'd7
	} err_t;

	localparam logic TT_SEL  = 1'b0;
	localparam logic TT_DECL = 1'b1;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_FF     = 8'h0C;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] ret;
		logic       has_chars;
		logic       last_space;
		logic       upend;
		logic       stuck;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       ttype;
		err_t       code;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR) ||
			(c == CH_FF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

endpackage

@@ sv/css_tok_step.sv @@
`timescale 1ns / 1ps

module css_tok_step (
	input  css_tok_pkg::state_t st,
	input  logic [7:0]          c,
	input  logic                eof,
	output css_tok_pkg::state_t nxt,
	output logic                res_v,
	output css_tok_pkg::res_t   res
);

	logic done;

	always_comb begin
		nxt   = st;
		res_v = 1'b0;
		res   = '0;
		done  = 1'b0;
		if (st.stuck) begin
			done = 1'b1;
		end else if (eof) begin
			done  = 1'b1;
			res_v = 1'b1;
			if (st.phase == css_tok_pkg::PH_CMT_OPEN) begin
				nxt.stuck = 1'b1;
				res.kind  = css_tok_pkg::K_ERR;
				res.code  = css_tok_pkg::E_BAD_CMT;
			end else if (st.phase == css_tok_pkg::PH_CMT_BODY ||
				st.phase == css_tok_pkg::PH_CMT_STAR) begin
				nxt.stuck = 1'b1;
				res.kind  = css_tok_pkg::K_ERR;
				res.code  = css_tok_pkg::E_OPEN_CMT;
			end else if (st.has_chars) begin
				nxt.stuck = 1'b1;
				res.kind  = css_tok_pkg::K_ERR;
				res.code  = css_tok_pkg::E_MID_TOKEN;
			end else begin
				res.kind = css_tok_pkg::K_EOF;
			end
		end else if (st.upend) begin
			nxt.upend = 1'b0;
			if (c == css_tok_pkg::CH_UNDER || css_tok_pkg::is_digit(c)) begin
				done      = 1'b1;
				res_v     = 1'b1;
				nxt.stuck = 1'b1;
				res.kind  = css_tok_pkg::K_ERR;
				res.code  = css_tok_pkg::E_UNDERSCORE;
			end
		end

		if (!done) begin
			unique case (st.phase)
				css_tok_pkg::PH_BEFORE_SEL, css_tok_pkg::PH_SEL: begin
					if (st.phase == css_tok_pkg::PH_BEFORE_SEL && css_tok_pkg::is_digit(c)) begin
						res_v     = 1'b1;
						nxt.stuck = 1'b1;
						res.kind  = css_tok_pkg::K_ERR;
						res.code  = css_tok_pkg::E_DIGIT_START;
					end else begin
						if (st.phase == css_tok_pkg::PH_BEFORE_SEL) begin
							nxt.upend = (c == css_tok_pkg::CH_UNDER);
							nxt.phase = css_tok_pkg::PH_SEL;
						end
						if (css_tok_pkg::is_ws(c)) begin
							nxt.phase = css_tok_pkg::PH_AFTER_SEL;
						end else if (c == css_tok_pkg::CH_LBRACE) begin
							nxt.phase     = css_tok_pkg::PH_BEFORE_DECL;
							nxt.has_chars = 1'b0;
							res_v         = 1'b1;
							res.kind      = css_tok_pkg::K_END;
							res.ttype     = css_tok_pkg::TT_SEL;
						end else if (css_tok_pkg::is_alpha(c) || css_tok_pkg::is_digit(c) ||
							c == css_tok_pkg::CH_UNDER || c == css_tok_pkg::CH_DASH ||
							c == css_tok_pkg::CH_COLON) begin
							nxt.has_chars = 1'b1;
							res_v         = 1'b1;
							res.kind      = css_tok_pkg::K_CHAR;
							res.ch        = c;
						end else begin
							res_v     = 1'b1;
							nxt.stuck = 1'b1;
							res.kind  = css_tok_pkg::K_ERR;
							res.code  = css_tok_pkg::E_BAD_SEL;
						end
					end
				end
				css_tok_pkg::PH_AFTER_SEL: begin
					if (css_tok_pkg::is_ws(c)) begin
						nxt.phase = st.phase;
					end else if (c == css_tok_pkg::CH_SLASH) begin
						nxt.ret   = 3'(css_tok_pkg::PH_AFTER_SEL);
						nxt.phase = css_tok_pkg::PH_CMT_OPEN;
					end else if (c == css_tok_pkg::CH_LBRACE) begin
						nxt.phase     = css_tok_pkg::PH_BEFORE_DECL;
						nxt.has_chars = 1'b0;
						res_v         = 1'b1;
						res.kind      = css_tok_pkg::K_END;
						res.ttype     = css_tok_pkg::TT_SEL;
					end else begin
						res_v     = 1'b1;
						nxt.stuck = 1'b1;
						res.kind  = css_tok_pkg::K_ERR;
						res.code  = css_tok_pkg::E_BAD_SEL;
					end
				end
				css_tok_pkg::PH_BEFORE_DECL, css_tok_pkg::PH_DECL: begin
					if (st.phase == css_tok_pkg::PH_BEFORE_DECL &&
						(css_tok_pkg::is_ws(c) || c == css_tok_pkg::CH_SEMI)) begin
						nxt.phase = st.phase;
					end else if (st.phase == css_tok_pkg::PH_BEFORE_DECL &&
						c == css_tok_pkg::CH_SLASH) begin
						nxt.ret   = 3'(css_tok_pkg::PH_BEFORE_DECL);
						nxt.phase = css_tok_pkg::PH_CMT_OPEN;
					end else if (st.phase == css_tok_pkg::PH_BEFORE_DECL &&
						c == css_tok_pkg::CH_RBRACE) begin
						nxt.phase = css_tok_pkg::PH_INITIAL;
					end else begin
						if (st.phase == css_tok_pkg::PH_BEFORE_DECL) begin
							nxt.phase      = css_tok_pkg::PH_DECL;
							nxt.has_chars  = 1'b0;
							nxt.last_space = 1'b0;
						end
						if (css_tok_pkg::is_ws(c)) begin
							if (nxt.has_chars && !nxt.last_space) begin
								nxt.last_space = 1'b1;
								res_v          = 1'b1;
								res.kind       = css_tok_pkg::K_CHAR;
								res.ch         = css_tok_pkg::CH_SPACE;
							end
						end else if (c == css_tok_pkg::CH_SEMI) begin
							nxt.phase      = css_tok_pkg::PH_BEFORE_DECL;
							nxt.has_chars  = 1'b0;
							nxt.last_space = 1'b0;
							res_v          = 1'b1;
							res.kind       = css_tok_pkg::K_END;
							res.ttype      = css_tok_pkg::TT_DECL;
						end else if (c == css_tok_pkg::CH_RBRACE) begin
							res_v     = 1'b1;
							nxt.stuck = 1'b1;
							res.kind  = css_tok_pkg::K_ERR;
							res.code  = css_tok_pkg::E_BRACE_DECL;
						end else begin
							nxt.has_chars  = 1'b1;
							nxt.last_space = 1'b0;
							res_v          = 1'b1;
							res.kind       = css_tok_pkg::K_CHAR;
							res.ch         = c;
						end
					end
				end
				css_tok_pkg::PH_CMT_OPEN: begin
					if (c != css_tok_pkg::CH_STAR) begin
						res_v     = 1'b1;
						nxt.stuck = 1'b1;
						res.kind  = css_tok_pkg::K_ERR;
						res.code  = css_tok_pkg::E_BAD_CMT;
					end else begin
						nxt.phase = css_tok_pkg::PH_CMT_BODY;
					end
				end
				css_tok_pkg::PH_CMT_BODY: begin
					if (c == css_tok_pkg::CH_STAR)
						nxt.phase = css_tok_pkg::PH_CMT_STAR;
				end
				css_tok_pkg::PH_CMT_STAR: begin
					if (c == css_tok_pkg::CH_SLASH)
						nxt.phase = css_tok_pkg::phase_t'({1'b0, st.ret});
					else if (c != css_tok_pkg::CH_STAR)
						nxt.phase = css_tok_pkg::PH_CMT_BODY;
				end
				default: begin
					nxt.phase = css_tok_pkg::PH_INITIAL;
					if (css_tok_pkg::is_ws(c)) begin
						nxt.phase = css_tok_pkg::PH_INITIAL;
					end else if (c == css_tok_pkg::CH_SLASH) begin
						nxt.ret   = 3'(css_tok_pkg::PH_INITIAL);
						nxt.phase = css_tok_pkg::PH_CMT_OPEN;
					end else if (c == css_tok_pkg::CH_DOT || c == css_tok_pkg::CH_HASH) begin
						nxt.phase     = css_tok_pkg::PH_BEFORE_SEL;
						nxt.has_chars = 1'b1;
						res_v         = 1'b1;
						res.kind      = css_tok_pkg::K_CHAR;
						res.ch        = c;
					end else begin
						res_v     = 1'b1;
						nxt.stuck = 1'b1;
						res.kind  = css_tok_pkg::K_ERR;
						res.code  = css_tok_pkg::E_BAD_START;
					end
				end
			endcase
		end
	end

endmodule

@@ sv/css_tok_outreg.sv @@
`timescale 1ns / 1ps

module css_tok_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  css_tok_pkg::res_t res,
	input  logic              ready,
	output logic              free,
	output logic              valid,
	output logic [1:0]        kind,
	output logic [7:0]        out_char,
	output logic              token_type,
	output logic [2:0]        error_code
);

	logic              valid_q;
	css_tok_pkg::res_t res_q;

	assign free = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load)
			res_q <= res;
	end

	assign valid      = valid_q;
	assign kind       = res_q.kind;
	assign out_char   = res_q.ch;
	assign token_type = res_q.ttype;
	assign error_code = res_q.code;

endmodule

@@ sv/css_rule_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// channel | signals                                   | dir
// in      | in_valid in_ready in_char end_of_input    | in
// out     | out_valid out_ready kind out_char         | out
//         | token_type error_code                     |
// One item per cycle while the result register is not stalled; path: input register, result register.
// An item that yields no result retires from the input register even while the
// result register is stalled; a yielding item waits there for the result register.
// Reset clears the parser state and both valid flags.
// After an error result no further results appear until reset.

module css_rule_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_char,
	output logic       token_type,
	output logic [2:0] error_code
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                eof_s1;
	css_tok_pkg::state_t state_q;
	css_tok_pkg::state_t state_nxt;
	logic                res_v;
	css_tok_pkg::res_t   res;
	logic                out_free;
	logic                fire_s1;

	assign fire_s1  = valid_s1 && (!res_v || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			eof_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: css_tok_pkg::PH_INITIAL, ret: 3'(css_tok_pkg::PH_INITIAL),
				has_chars: 1'b0, last_space: 1'b0, upend: 1'b0, stuck: 1'b0};
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	css_tok_step u_step (
		.st    (state_q),
		.c     (char_s1),
		.eof   (eof_s1),
		.nxt   (state_nxt),
		.res_v (res_v),
		.res   (res)
	);

	css_tok_outreg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire_s1 && res_v),
		.res        (res),
		.ready      (out_ready),
		.free       (out_free),
		.valid      (out_valid),
		.kind       (kind),
		.out_char   (out_char),
		.token_type (token_type),
		.error_code (error_code)
	);

endmodule

@@ sv/css_tok_chk.sv @@
`timescale 1ns / 1ps

module css_tok_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] out_char,
	input logic       token_type,
	input logic [2:0] error_code
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char) &&
			$stable(token_type) && $stable(error_code))
		else $error("result changed while stalled");

	a_quiet_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == css_tok_pkg::K_ERR |=> !out_valid)
		else $error("result after error");

	a_code_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != css_tok_pkg::K_ERR |-> error_code == 3'd0)
		else $error("error code outside error item");

	a_type_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != css_tok_pkg::K_END |-> token_type == 1'b0 &&
			(kind == css_tok_pkg::K_CHAR || out_char == 8'd0))
		else $error("stray payload bits");

endmodule

bind css_rule_tokenizer_unit css_tok_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.out_char   (out_char),
	.token_type (token_type),
	.error_code (error_code)
);

@@ test/css_rule_tokenizer_unit_tb.sv @@
`timescale 1ns / 1ps

module css_rule_tokenizer_unit_tb;
	import css_tok_pkg::*;

	localparam int LIMIT = 200000;
	localparam err_t CODE_NONE = E_BAD_START;

	typedef struct {
		logic [7:0] ch;
		bit         eoi;
		bit         drain;
	} char_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_char;
	logic       token_type;
	logic [2:0] error_code;

	char_item_t pending_chars[$];
	res_t       expected_tokens[$];

	// tokenizer state as predicted
	phase_t     ps_phase = PH_INITIAL;
	logic [2:0] ps_ret = '0;
	bit         ps_chars = 0;
	bit         ps_space = 0;
	bit         ps_under = 0;
	bit         ps_dead = 0;

	bit in_fire = 0;
	bit calm = 0;
	bit long_stall_done = 0;
	int send_gap = 0;
	int ready_gap = 0;
	int stall_left = 0;
	int accepted_cnt = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	css_rule_tokenizer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_char(in_char),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_char(out_char),
		.token_type(token_type),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	function automatic bit blank_char(input logic [7:0] c);
		return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR, CH_FF};
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic bit alpha_char(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic res_t token_result(input kind_t k, input logic [7:0] ch,
			input logic tt, input err_t code);
		res_t v;
		v.kind = k;
		v.ch = ch;
		v.ttype = tt;
		v.code = code;
		return v;
	endfunction

	function automatic bit fail_with(input err_t code, output res_t r);
		ps_dead = 1;
		r = token_result(K_ERR, 8'h00, TT_SEL, code);
		return 1;
	endfunction

	function automatic void open_cmt(input phase_t back);
		ps_ret = 3'(back);
		ps_phase = PH_CMT_OPEN;
	endfunction

	function automatic bit sel_step(input logic [7:0] c, output res_t r);
		if (blank_char(c)) begin
			ps_phase = PH_AFTER_SEL;
			return 0;
		end
		if (c == CH_LBRACE) begin
			ps_phase = PH_BEFORE_DECL;
			ps_chars = 0;
			r = token_result(K_END, 8'h00, TT_SEL, CODE_NONE);
			return 1;
		end
		if (alpha_char(c) || digit_char(c) || c inside {CH_UNDER, CH_DASH, CH_COLON}) begin
			ps_chars = 1;
			r = token_result(K_CHAR, c, TT_SEL, CODE_NONE);
			return 1;
		end
		return fail_with(E_BAD_SEL, r);
	endfunction

	function automatic bit decl_step(input logic [7:0] c, output res_t r);
		if (blank_char(c)) begin
			if (ps_chars && !ps_space) begin
				ps_space = 1;
				r = token_result(K_CHAR, CH_SPACE, TT_SEL, CODE_NONE);
				return 1;
			end
			return 0;
		end
		if (c == CH_SEMI) begin
			ps_phase = PH_BEFORE_DECL;
			ps_chars = 0;
			ps_space = 0;
			r = token_result(K_END, 8'h00, TT_DECL, CODE_NONE);
			return 1;
		end
		if (c == CH_RBRACE)
			return fail_with(E_BRACE_DECL, r);
		ps_chars = 1;
		ps_space = 0;
		r = token_result(K_CHAR, c, TT_SEL, CODE_NONE);
		return 1;
	endfunction

	function automatic bit tokenize_step(input logic [7:0] c, input logic eoi, output res_t r);
		r = '0;
		if (ps_dead)
			return 0;
		if (eoi) begin
			if (ps_phase == PH_CMT_OPEN)
				return fail_with(E_BAD_CMT, r);
			if (ps_phase inside {PH_CMT_BODY, PH_CMT_STAR})
				return fail_with(E_OPEN_CMT, r);
			if (ps_chars)
				return fail_with(E_MID_TOKEN, r);
			r = token_result(K_EOF, 8'h00, TT_SEL, CODE_NONE);
			return 1;
		end
		if (ps_under) begin
			ps_under = 0;
			if (c == CH_UNDER || digit_char(c))
				return fail_with(E_UNDERSCORE, r);
		end
		case (ps_phase)
			PH_BEFORE_SEL: begin
				if (digit_char(c))
					return fail_with(E_DIGIT_START, r);
				if (c == CH_UNDER)
					ps_under = 1;
				ps_phase = PH_SEL;
				return sel_step(c, r);
			end
			PH_SEL: return sel_step(c, r);
			PH_AFTER_SEL: begin
				if (blank_char(c))
					return 0;
				if (c == CH_SLASH) begin
					open_cmt(PH_AFTER_SEL);
					return 0;
				end
				if (c == CH_LBRACE) begin
					ps_phase = PH_BEFORE_DECL;
					ps_chars = 0;
					r = token_result(K_END, 8'h00, TT_SEL, CODE_NONE);
					return 1;
				end
				return fail_with(E_BAD_SEL, r);
			end
			PH_BEFORE_DECL: begin
				if (blank_char(c) || c == CH_SEMI)
					return 0;
				if (c == CH_SLASH) begin
					open_cmt(PH_BEFORE_DECL);
					return 0;
				end
				if (c == CH_RBRACE) begin
					ps_phase = PH_INITIAL;
					return 0;
				end
				ps_phase = PH_DECL;
				ps_chars = 0;
				ps_space = 0;
				return decl_step(c, r);
			end
			PH_DECL: return decl_step(c, r);
			PH_CMT_OPEN: begin
				if (c != CH_STAR)
					return fail_with(E_BAD_CMT, r);
				ps_phase = PH_CMT_BODY;
				return 0;
			end
			PH_CMT_BODY: begin
				if (c == CH_STAR)
					ps_phase = PH_CMT_STAR;
				return 0;
			end
			PH_CMT_STAR: begin
				if (c == CH_SLASH)
					ps_phase = phase_t'({1'b0, ps_ret});
				else if (c != CH_STAR)
					ps_phase = PH_CMT_BODY;
				return 0;
			end
			default: begin
				ps_phase = PH_INITIAL;
				if (blank_char(c))
					return 0;
				if (c == CH_SLASH) begin
					open_cmt(PH_INITIAL);
					return 0;
				end
				if (c == CH_DOT || c == CH_HASH) begin
					ps_phase = PH_BEFORE_SEL;
					ps_chars = 1;
					r = token_result(K_CHAR, c, TT_SEL, CODE_NONE);
					return 1;
				end
				return fail_with(E_BAD_START, r);
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_LF;
			2: return CH_TAB;
			3: return CH_CR;
			default: return CH_FF;
		endcase
	endfunction

	// plain: no underscore and no digit
	function automatic logic [7:0] name_char(input bit plain);
		case ($urandom_range(0, plain ? 2 : 4))
			0: return 8'($urandom_range("a", "z"));
			1: return 8'($urandom_range("A", "Z"));
			2: return $urandom_range(0, 1) ? CH_DASH : CH_COLON;
			3: return CH_UNDER;
			default: return 8'($urandom_range("0", "9"));
		endcase
	endfunction

	task automatic put_item(input logic [7:0] c, input bit eoi, input bit drain);
		char_item_t it;
		it.ch = c;
		it.eoi = eoi;
		it.drain = drain;
		pending_chars = {pending_chars, it};
	endtask

	task automatic put_char(input logic [7:0] c);
		put_item(c, 0, 0);
	endtask

	task automatic put_eof();
		put_item(8'($urandom_range(0, 255)), 1, 0);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_comment();
		logic [7:0] c;
		logic [7:0] prev;
		prev = 8'h00;
		put_char(CH_SLASH);
		put_char(CH_STAR);
		repeat ($urandom_range(0, 10)) begin
			c = 8'($urandom_range(0, 255));
			if (prev == CH_STAR && c == CH_SLASH)
				c = CH_STAR;
			put_char(c);
			prev = c;
		end
		repeat ($urandom_range(1, 3))
			put_char(CH_STAR);
		put_char(CH_SLASH);
	endtask

	task automatic put_gap(input int maxn, input bit cmt);
		repeat ($urandom_range(0, maxn))
			put_char(pick_blank());
		if (cmt && $urandom_range(0, 4) == 0) begin
			put_comment();
			repeat ($urandom_range(0, 1))
				put_char(pick_blank());
		end
	endtask

	task automatic put_selector();
		int n;
		logic [7:0] c;
		c = 8'h00;
		put_char($urandom_range(0, 1) ? CH_DOT : CH_HASH);
		n = $urandom_range(0, 8);
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				c = ($urandom_range(0, 4) == 0) ? CH_UNDER : name_char(1);
			else if (i == 1 && c == CH_UNDER)
				c = name_char(1);
			else
				c = name_char(0);
			put_char(c);
		end
		if ($urandom_range(0, 1)) begin
			put_char(CH_LBRACE);
		end else begin
			put_char(pick_blank());
			put_gap(3, 1);
			put_char(CH_LBRACE);
		end
	endtask

	task automatic put_decl();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (blank_char(c) || c inside {CH_SEMI, CH_SLASH, CH_RBRACE});
		put_char(c);
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 3) == 0) begin
				c = pick_blank();
			end else begin
				do
					c = 8'($urandom_range(0, 255));
				while (c inside {CH_SEMI, CH_RBRACE});
			end
			put_char(c);
		end
		if ($urandom_range(0, 2) == 0)
			put_char(pick_blank());
		put_char(CH_SEMI);
	endtask

	task automatic put_rule();
		put_gap(3, 1);
		put_selector();
		if ($urandom_range(0, 9) == 0)
			put_eof();
		repeat ($urandom_range(0, 4)) begin
			put_gap(2, 1);
			if ($urandom_range(0, 7) == 0)
				put_char(CH_SEMI);
			put_decl();
		end
		put_gap(2, 1);
		put_char(CH_RBRACE);
		if ($urandom_range(0, 5) == 0)
			put_eof();
	endtask

	task automatic flag_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// prediction on accept, checking on result
	always @(posedge clk) begin
		res_t want;
		cycle_cnt++;
		in_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			accepted_cnt++;
			if (tokenize_step(in_char, end_of_input, want))
				expected_tokens = {expected_tokens, want};
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d char %h type %0d code %0d",
					kind, out_char, token_type, error_code));
			end else begin
				want = expected_tokens.pop_front();
				if (kind !== want.kind || out_char !== want.ch ||
						token_type !== want.ttype || error_code !== want.code)
					flag_mismatch($sformatf(
						"exp kind %0d char %h type %0d code %0d, got %0d %h %0d %0d",
						want.kind, want.ch, want.ttype, want.code,
						kind, out_char, token_type, error_code));
			end
		end
		if (cycle_cnt > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// sender
	always @(negedge clk) begin
		char_item_t it;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_chars.size() > 0 &&
					!(pending_chars[0].drain && expected_tokens.size() > 0)) begin
				it = pending_chars.pop_front();
				in_valid <= 1'b1;
				in_char <= it.ch;
				end_of_input <= it.eoi;
				send_gap <= pick_gap();
				if ($urandom_range(0, 199) == 0)
					calm <= !calm;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		int g;
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!long_stall_done && accepted_cnt >= 500) begin
				out_ready <= 1'b0;
				stall_left <= 400;
				long_stall_done <= 1;
			end else if (ready_gap > 0) begin
				out_ready <= 1'b0;
				ready_gap <= ready_gap - 1;
			end else begin
				g = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
				out_ready <= (g == 0);
				ready_gap <= (g > 0) ? g - 1 : 0;
			end
		end
	end

	initial begin
		bit drained;
		err_t last_err;
		drained = 0;

		put_char(CH_FF);
		put_text(" /**x**/#_a-:Z9\t{;k");
		put_char(8'hFF);
		put_text("  ");
		put_char(8'h00);
		put_text(";}");
		put_eof();

		while (pending_chars.size() < 1450) begin
			if (!drained && pending_chars.size() > 700) begin
				put_item(CH_SPACE, 0, 1);
				drained = 1;
			end
			put_rule();
		end

		// one error per run; after it the block stays silent
		last_err = err_t'($urandom_range(0, 7));
		case (last_err)
			E_BAD_START: put_char("x");
			E_DIGIT_START: put_text(".7");
			E_UNDERSCORE: put_text($urandom_range(0, 1) ? "#__" : "._4");
			E_BAD_SEL: put_text($urandom_range(0, 1) ? ".ab!" : ".ab c");
			E_BAD_CMT: begin
				if ($urandom_range(0, 1)) begin
					put_text("/a");
				end else begin
					put_char(CH_SLASH);
					put_eof();
				end
			end
			E_OPEN_CMT: begin
				put_text("/* x *");
				put_eof();
			end
			E_BRACE_DECL: put_text(".a{b}");
			default: begin
				put_text(".ab");
				put_eof();
			end
		endcase
		repeat (8)
			put_char(8'($urandom_range(0, 255)));
		put_eof();

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		wait (pending_chars.size() == 0 && !in_valid);
		wait (expected_tokens.size() == 0);
		repeat (10) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/css_tok_pkg.sv
sv/css_tok_step.sv
sv/css_tok_outreg.sv
sv/css_rule_tokenizer_unit.sv
sv/css_tok_chk.sv
test/css_rule_tokenizer_unit_tb.sv
